[rtl/all_pairs_shortest_path_core_assert.svh]
// ----------------------------------------------------------------------------
// all-pairs shortest path core: assertion macros
// shared concurrent property wrappers, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define APS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define APS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/aps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_pkg
// shared types and constants of the all-pairs shortest path core
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int DIST_BITS      = 20;
  localparam int NODE_BITS      = 4;
  localparam int WEIGHT_IN_BITS = 16;
  localparam int VCOUNT_BITS    = 5;
  localparam int OP_BITS        = 2;
  localparam int IN_DATA_BITS   = 24;
  localparam int OUT_DATA_BITS  = 24;

  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RST = 5'd16;
  localparam logic [DIST_BITS-1:0]   DIST_MAX   = '1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [NODE_BITS-1:0]      node_a;
    logic [NODE_BITS-1:0]      node_b;
    logic [WEIGHT_IN_BITS-1:0] weight;
  } req_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 reachable;
    logic                 status;
  } resp_t;

  // one distance store entry: reachable mark plus distance
  typedef struct packed {
    logic                 valid;
    logic [DIST_BITS-1:0] len;
  } dist_ent_t;

endpackage

[rtl/aps_relax.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_relax
// one relaxation step: saturating path sum through the pivot and compare
// ----------------------------------------------------------------------------
module aps_relax
  import aps_pkg::*;
(
  input  dist_ent_t uk_i,
  input  dist_ent_t kv_i,
  input  dist_ent_t uv_i,
  output logic      we_o,
  output dist_ent_t val_o
);

  logic [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0] sat;

  assign sum = {1'b0, uk_i.len} + {1'b0, kv_i.len};
  assign sat = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];

  assign we_o        = uk_i.valid && kv_i.valid && (!uv_i.valid || (sat < uv_i.len));
  assign val_o.valid = 1'b1;
  assign val_o.len   = sat;

endmodule

[rtl/aps_engine.sv]
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_core_assert.svh"
// ----------------------------------------------------------------------------
// aps_engine
// edge and distance stores with the sweep and relaxation sequencer
// ----------------------------------------------------------------------------
module aps_engine
  import aps_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  localparam int CW          = $clog2(MAX_VERTICES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [CW-1:0] n_i,
  input  logic          start_i,
  input  req_t          req_i,
  output logic          idle_o,
  output logic          resp_valid_o,
  output resp_t         resp_o,
  input  logic          resp_take_i
);

  localparam int VB    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * VB;
  localparam int DEPTH = 1 << AW;
  localparam int EW    = WEIGHT_BITS + 1;
  localparam int CMPW  = (CW > NODE_BITS) ? CW : NODE_BITS;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_ADD_AB,
    ST_ADD_BA,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_COPY,
    ST_ROW,
    ST_ROWCHK,
    ST_COL,
    ST_RESP
  } state_t;

  function automatic logic [VB-1:0] node_idx(input logic [NODE_BITS-1:0] node);
    logic [VB+NODE_BITS-1:0] t;
    t = {{VB{1'b0}}, node};
    return t[VB-1:0];
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] weight_fit(input logic [WEIGHT_IN_BITS-1:0] w);
    logic [WEIGHT_BITS+WEIGHT_IN_BITS-1:0] t;
    t = {{WEIGHT_BITS{1'b0}}, w};
    return t[WEIGHT_BITS-1:0];
  endfunction

  function automatic dist_ent_t edge_to_dist(input logic [EW-1:0] e);
    logic [DIST_BITS+WEIGHT_BITS-1:0] t;
    dist_ent_t                        d;
    t       = {{DIST_BITS{1'b0}}, e[WEIGHT_BITS-1:0]};
    d.valid = e[EW-1];
    d.len   = t[DIST_BITS-1:0];
    return d;
  endfunction

  function automatic logic on_diag(input logic [AW-1:0] addr);
    return addr[AW-1:VB] == addr[VB-1:0];
  endfunction

  // stores
  logic [EW-1:0] edge_mem [DEPTH];
  dist_ent_t     dist_mem [DEPTH];

  // sequencer registers
  state_t           state_r;
  logic [AW-1:0]    sw_r;
  logic [VB-1:0]    k_r, u_r, v_r;
  logic [VB-1:0]    a_r, b_r;
  logic [WEIGHT_BITS-1:0] w_r;
  resp_t            res_r;
  dist_ent_t        uk_r;
  logic             cp_vld_r;
  logic [AW-1:0]    cp_addr_r;
  logic             p_vld_r;
  logic [AW-1:0]    p_addr_r;

  // memory ports
  logic          e_we;
  logic [AW-1:0] e_waddr;
  logic [EW-1:0] e_wdata;
  logic [EW-1:0] e_rdata_r;
  logic          d_we;
  logic [AW-1:0] d_waddr;
  dist_ent_t     d_wdata;
  logic [AW-1:0] d_raddr_a, d_raddr_b;
  dist_ent_t     d_rdata_a_r, d_rdata_b_r;

  logic      relax_we;
  dist_ent_t relax_val;

  logic bad_node;
  logic last_u, last_v, last_k;

  aps_relax u_relax (
    .uk_i  (uk_r),
    .kv_i  (d_rdata_a_r),
    .uv_i  (d_rdata_b_r),
    .we_o  (relax_we),
    .val_o (relax_val)
  );

  assign bad_node = (CMPW'(req_i.node_a) >= CMPW'(n_i)) ||
                    (CMPW'(req_i.node_b) >= CMPW'(n_i));
  assign last_v   = (CW'(v_r) + CW'(1)) == n_i;
  assign last_u   = (CW'(u_r) + CW'(1)) == n_i;
  assign last_k   = (CW'(k_r) + CW'(1)) == n_i;

  // edge store port control
  always_comb begin
    e_we    = 1'b0;
    e_waddr = sw_r;
    e_wdata = {on_diag(sw_r), {WEIGHT_BITS{1'b0}}};
    case (state_r)
      ST_INIT, ST_CLR: begin
        e_we = 1'b1;
      end
      ST_ADD_AB: begin
        e_we    = 1'b1;
        e_waddr = {a_r, b_r};
        e_wdata = {1'b1, w_r};
      end
      ST_ADD_BA: begin
        e_we    = 1'b1;
        e_waddr = {b_r, a_r};
        e_wdata = {1'b1, w_r};
      end
      default: begin
        e_we = 1'b0;
      end
    endcase
  end

  // distance store port control
  always_comb begin
    d_we    = 1'b0;
    d_waddr = sw_r;
    d_wdata = '{valid: on_diag(sw_r), len: '0};
    if (state_r == ST_INIT) begin
      d_we = 1'b1;
    end else if (cp_vld_r) begin
      d_we    = 1'b1;
      d_waddr = cp_addr_r;
      d_wdata = edge_to_dist(e_rdata_r);
    end else if (p_vld_r && relax_we) begin
      d_we    = 1'b1;
      d_waddr = p_addr_r;
      d_wdata = relax_val;
    end
  end

  assign d_raddr_a = (state_r == ST_ROW) ? {u_r, k_r} : {k_r, v_r};
  assign d_raddr_b = (state_r == ST_RD_ISSUE) ? {a_r, b_r} : {u_r, v_r};

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    e_rdata_r <= edge_mem[sw_r];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dist_mem[d_waddr] <= d_wdata;
    end
    d_rdata_a_r <= dist_mem[d_raddr_a];
    d_rdata_b_r <= dist_mem[d_raddr_b];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      sw_r     <= '0;
      cp_vld_r <= 1'b0;
      p_vld_r  <= 1'b0;
    end else begin
      cp_vld_r  <= (state_r == ST_COPY);
      cp_addr_r <= sw_r;
      p_vld_r   <= (state_r == ST_COL);
      p_addr_r  <= {u_r, v_r};
      case (state_r)
        ST_INIT: begin
          sw_r <= sw_r + 1'b1;
          if (&sw_r) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start_i) begin
            a_r   <= node_idx(req_i.node_a);
            b_r   <= node_idx(req_i.node_b);
            w_r   <= weight_fit(req_i.weight);
            // add edge and read refuse vertices past the count
            res_r <= '{distance: '0, reachable: 1'b0,
                       status: (((req_i.op == OP_ADD) || (req_i.op == OP_READ)) && bad_node) ?
                               STATUS_RANGE : STATUS_OK};
            sw_r  <= '0;
            k_r   <= '0;
            u_r   <= '0;
            v_r   <= '0;
            case (req_i.op)
              OP_CLEAR:   state_r <= ST_CLR;
              OP_COMPUTE: state_r <= ST_COPY;
              OP_ADD: begin
                if (bad_node) begin
                  state_r <= ST_RESP;
                end else begin
                  state_r <= ST_ADD_AB;
                end
              end
              OP_READ: begin
                if (bad_node) begin
                  state_r <= ST_RESP;
                end else begin
                  state_r <= ST_RD_ISSUE;
                end
              end
              default: state_r <= ST_RESP;
            endcase
          end
        end
        ST_CLR: begin
          sw_r <= sw_r + 1'b1;
          if (&sw_r) state_r <= ST_RESP;
        end
        ST_ADD_AB: state_r <= ST_ADD_BA;
        ST_ADD_BA: state_r <= ST_RESP;
        ST_RD_ISSUE: state_r <= ST_RD_WAIT;
        ST_RD_WAIT: begin
          res_r.distance  <= d_rdata_b_r.valid ? d_rdata_b_r.len : '0;
          res_r.reachable <= d_rdata_b_r.valid;
          state_r         <= ST_RESP;
        end
        ST_COPY: begin
          sw_r <= sw_r + 1'b1;
          if (&sw_r) state_r <= (n_i == '0) ? ST_RESP : ST_ROW;
        end
        ST_ROW: state_r <= ST_ROWCHK;
        ST_ROWCHK, ST_COL: begin
          if (state_r == ST_ROWCHK) begin
            uk_r <= d_rdata_a_r;
            v_r  <= '0;
          end else begin
            v_r <= v_r + 1'b1;
          end
          if ((state_r == ST_ROWCHK) && d_rdata_a_r.valid) begin
            state_r <= ST_COL;
          end else if ((state_r == ST_ROWCHK) || last_v) begin
            // row done or skipped: next source, then next pivot
            if (!last_u) begin
              u_r     <= u_r + 1'b1;
              state_r <= ST_ROW;
            end else if (!last_k) begin
              u_r     <= '0;
              k_r     <= k_r + 1'b1;
              state_r <= ST_ROW;
            end else begin
              state_r <= ST_RESP;
            end
          end
        end
        ST_RESP: begin
          if (resp_take_i) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign idle_o       = (state_r == ST_IDLE);
  assign resp_valid_o = (state_r == ST_RESP);
  assign resp_o       = res_r;

  `APS_ASSERT_NEXT(a_start_leaves_idle, start_i, state_r != ST_IDLE, "request left engine idle")
  `APS_ASSERT_NOW(a_one_dist_writer, cp_vld_r, !p_vld_r, "copy and relax writes overlap")
  `APS_ASSERT_NOW(a_col_in_range, state_r == ST_COL, (CW'(v_r) < n_i) && (CW'(u_r) < n_i), "sweep index past vertex count")
  `APS_ASSERT_NOW(a_relax_off_pivot, p_vld_r && relax_we, (p_addr_r[AW-1:VB] != $past(k_r)) && (p_addr_r[VB-1:0] != $past(k_r)), "relax wrote pivot row or column")

endmodule

[rtl/all_pairs_shortest_path_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core
// undirected weighted graph engine with floyd-warshall all-pairs solve
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  in_       request    in_tvalid/in_tready  tdata: node_a, node_b, weight; tuser: op
//  out_      result     out_tvalid/out_tready tdata: distance, reachable; tuser: status
//  cfg_      register   cfg_we               cfg_wdata: vertex_count
//
//  one request at a time; a finished result sits in the output register so the
//  next request is taken while the result waits
//  read: issue, wait, result; add edge: each direction, result; out-of-range: result
//  clear: one edge store entry a cycle over all 2^(2*clog2(MAX_VERTICES)) (256 at 16)
//  compute: copy sweep of the same length, then per pivot and source a row read and
//    check, plus a column sweep of one relaxation per cycle through the distance
//    store ports when the source reaches the pivot
//  after reset both stores are swept (all 256 entries at default) with in_tready low
//
module all_pairs_shortest_path_core
  import aps_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // node_a[3:0], node_b[7:4], weight[23:8]
  input  logic [OP_BITS-1:0]       in_tuser,   // op[1:0]
  // result channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // distance[19:0], reachable[20], zero pad
  output logic                     out_tuser,  // status[0]
  // vertex count register
  input  logic                     cfg_we,
  input  logic [VCOUNT_BITS-1:0]   cfg_wdata
);

  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [VCOUNT_BITS-1:0] vc_r;
  logic [CW-1:0]          n_eff;

  req_t  req;
  logic  start;
  logic  eng_idle;
  logic  resp_valid;
  resp_t resp;
  logic  resp_take;

  logic  out_vld_r;
  resp_t out_r;

  // vertex count register, counts above the store size act as the full size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VCOUNT_RST;
    end else if (cfg_we) begin
      vc_r <= cfg_wdata;
    end
  end

  assign n_eff = (int'(vc_r) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vc_r);

  // request unpack
  assign req.op     = op_t'(in_tuser);
  assign req.node_a = in_tdata[NODE_BITS-1:0];
  assign req.node_b = in_tdata[2*NODE_BITS-1:NODE_BITS];
  assign req.weight = in_tdata[2*NODE_BITS+WEIGHT_IN_BITS-1:2*NODE_BITS];

  assign in_tready = eng_idle;
  assign start     = in_tvalid && eng_idle;

  aps_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .n_i          (n_eff),
    .start_i      (start),
    .req_i        (req),
    .idle_o       (eng_idle),
    .resp_valid_o (resp_valid),
    .resp_o       (resp),
    .resp_take_i  (resp_take)
  );

  // output register: loads when empty or being drained this cycle
  assign resp_take = resp_valid && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      if (resp_take) begin
        out_vld_r <= 1'b1;
        out_r     <= resp;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_BITS-DIST_BITS-1){1'b0}}, out_r.reachable, out_r.distance};
  assign out_tuser  = out_r.status;

endmodule

[tb/all_pairs_shortest_path_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core_test
// self-checking bench for the shortest path core: a clocked driver feeds
// requests from a backlog queue, a clocked monitor checks every result against
// a graph model kept here, and both sides idle and stall at random
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_core_test;
  import aps_pkg::*;

  localparam int NV            = MAX_VERTICES_DEF;
  localparam int RANDOM_ITEMS  = 105;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam logic [WEIGHT_IN_BITS-1:0] W_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic [OP_BITS-1:0]       in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tuser;
  logic                     cfg_we = 1'b0;
  logic [VCOUNT_BITS-1:0]   cfg_wdata = '0;

  all_pairs_shortest_path_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // graph model: edge weights, solved distances and the vertex count register
  // --------------------------------------------------------------------------
  logic [WEIGHT_IN_BITS-1:0] edge_len   [NV][NV];
  bit                        edge_known [NV][NV];
  logic [DIST_BITS-1:0]      path_len   [NV][NV];
  bit                        path_known [NV][NV];
  logic [VCOUNT_BITS-1:0]    vcount_shadow;

  // queues: requests waiting to be driven, answers waiting to come back
  req_t  request_backlog[$];
  resp_t expected_answers[$];

  // bookkeeping
  int error_count = 0;
  int answers_seen = 0;
  int queued_total = 0;
  int op_tally[4] = '{0, 0, 0, 0};
  int reach_count = 0;
  int range_count = 0;
  int vcount_writes = 0;
  int cycle_count = 0;

  // no edges anywhere, every vertex at distance zero from itself
  function automatic void wipe_edges();
    for (int u = 0; u < NV; u++) begin
      for (int v = 0; v < NV; v++) begin
        edge_len[u][v]   = '0;
        edge_known[u][v] = (u == v);
      end
    end
  endfunction

  // applies one request to the model and returns the answer it must produce
  function automatic resp_t graph_answer(input req_t r);
    resp_t       ans;
    int          n;
    int unsigned sum;
    ans = '0;
    ans.status = STATUS_OK;
    n = (vcount_shadow > NV) ? NV : int'(vcount_shadow);
    case (r.op)
      OP_CLEAR: begin
        // distances stay as they were until the next solve
        wipe_edges();
      end
      OP_COMPUTE: begin
        // whole edge matrix is copied, only the active corner is relaxed
        for (int u = 0; u < NV; u++) begin
          for (int v = 0; v < NV; v++) begin
            path_len[u][v]   = DIST_BITS'(edge_len[u][v]);
            path_known[u][v] = edge_known[u][v];
          end
        end
        for (int k = 0; k < n; k++) begin
          for (int u = 0; u < n; u++) begin
            if (path_known[u][k]) begin
              for (int v = 0; v < n; v++) begin
                if (path_known[k][v]) begin
                  sum = path_len[u][k] + path_len[k][v];
                  if (sum > DIST_MAX) sum = DIST_MAX;
                  if (!path_known[u][v] || sum < path_len[u][v]) begin
                    path_len[u][v]   = DIST_BITS'(sum);
                    path_known[u][v] = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      default: begin
        if (r.node_a >= n || r.node_b >= n) begin
          ans.status = STATUS_RANGE;
        end else if (r.op == OP_ADD) begin
          edge_len[r.node_a][r.node_b]   = r.weight;
          edge_known[r.node_a][r.node_b] = 1'b1;
          edge_len[r.node_b][r.node_a]   = r.weight;
          edge_known[r.node_b][r.node_a] = 1'b1;
        end else if (path_known[r.node_a][r.node_b]) begin
          ans.distance  = path_len[r.node_a][r.node_b];
          ans.reachable = 1'b1;
        end
      end
    endcase
    return ans;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers the backlog one request at a time, predicts on acceptance
  // --------------------------------------------------------------------------
  req_t  offered;
  resp_t predicted;
  int    src_gap = 0;
  bit    src_steady = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted = graph_answer(offered);
        expected_answers.push_back(predicted);
        op_tally[offered.op]++;
        if (predicted.status == STATUS_RANGE) range_count++;
        if (predicted.reachable) reach_count++;
        if ($urandom_range(0, 29) == 0) src_steady <= !src_steady;
      end
      // the slot is free when nothing is offered or the offer just went in
      if (!in_tvalid || in_tready) begin
        if (src_gap != 0) begin
          src_gap   <= src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          offered = request_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {offered.weight, offered.node_b, offered.node_a};
          in_tuser  <= offered.op;
          src_gap   <= src_steady ? 0 : idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each result against the oldest answer, drives out_tready
  // --------------------------------------------------------------------------
  resp_t want;
  int    sink_wait = 0;
  bit    sink_steady = 1'b0;
  bit    long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        answers_seen++;
        if ($urandom_range(0, 39) == 0) sink_steady <= !sink_steady;
        if (expected_answers.size() == 0) begin
          $display("%0t: result with no request pending: distance %0d reachable %0b status %0b",
                   $time, out_tdata[DIST_BITS-1:0], out_tdata[DIST_BITS], out_tuser);
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          if (out_tdata[DIST_BITS-1:0] !== want.distance) begin
            $display("%0t: distance mismatch: expected %0d, got %0d",
                     $time, want.distance, out_tdata[DIST_BITS-1:0]);
            error_count++;
          end
          if (out_tdata[DIST_BITS] !== want.reachable) begin
            $display("%0t: reachable mismatch: expected %0b, got %0b",
                     $time, want.reachable, out_tdata[DIST_BITS]);
            error_count++;
          end
          if (out_tuser !== want.status) begin
            $display("%0t: status mismatch: expected %0b, got %0b",
                     $time, want.status, out_tuser);
            error_count++;
          end
        end
      end
      // one long hold-off while the driver still has requests queued, so the
      // output register and the request slot both fill and in_tready drops
      if (!long_hold_done && answers_seen >= 20 && request_backlog.size() >= 3) begin
        long_hold_done <= 1'b1;
        sink_wait      <= LONG_HOLD;
        out_tready     <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait  <= sink_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 3) == 0) sink_wait <= idle_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers still pending",
               cycle_count, expected_answers.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_req(input op_t op, input logic [NODE_BITS-1:0] a,
                           input logic [NODE_BITS-1:0] b,
                           input logic [WEIGHT_IN_BITS-1:0] w);
    req_t r;
    r.op     = op;
    r.node_a = a;
    r.node_b = b;
    r.weight = w;
    request_backlog.push_back(r);
    queued_total++;
  endtask

  // nothing queued, nothing in flight, nothing outstanding
  task automatic wait_idle();
    while (request_backlog.size() != 0 || expected_answers.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [VCOUNT_BITS-1:0] vc);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= vc;
    vcount_shadow = vc;
    vcount_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly vertices in use, sometimes any index the field can carry
  function automatic logic [NODE_BITS-1:0] pick_node(input int eff);
    if (eff > 0 && $urandom_range(0, 99) < 85) return NODE_BITS'($urandom_range(0, eff - 1));
    return NODE_BITS'($urandom_range(0, NV - 1));
  endfunction

  function automatic logic [WEIGHT_IN_BITS-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return W_MAX;
    if (r < 40) return '0;
    if (r < 60) return WEIGHT_IN_BITS'($urandom_range(1, 15));
    return WEIGHT_IN_BITS'($urandom_range(0, 65535));
  endfunction

  task automatic queue_noise();
    op_t op;
    op = op_t'($urandom_range(0, 3));
    // solves are slow, keep them rare among noise
    if (op == OP_COMPUTE && $urandom_range(0, 1) == 0) op = OP_READ;
    queue_req(op, NODE_BITS'($urandom_range(0, 15)), NODE_BITS'($urandom_range(0, 15)),
              pick_weight());
  endtask

  // one graph: load edges, solve, ask for distances; or a burst of noise
  task automatic graph_session(input logic [VCOUNT_BITS-1:0] vc);
    int eff;
    set_vertex_count(vc);
    eff = (vc > NV) ? NV : int'(vc);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(4, 8)) queue_noise();
    end else begin
      if ($urandom_range(0, 9) != 0)
        queue_req(OP_CLEAR, NODE_BITS'($urandom_range(0, 15)),
                  NODE_BITS'($urandom_range(0, 15)), pick_weight());
      repeat ($urandom_range(1, eff + 3))
        queue_req(OP_ADD, pick_node(eff), pick_node(eff), pick_weight());
      queue_req(OP_COMPUTE, NODE_BITS'($urandom_range(0, 15)),
                NODE_BITS'($urandom_range(0, 15)), pick_weight());
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_req(OP_READ, pick_node(eff), pick_node(eff), pick_weight());
      end
    end
  endtask

  logic [VCOUNT_BITS-1:0] vc_plan [12];
  int directed_end;
  int plan_idx;

  initial begin
    vc_plan = '{5'd5, 5'd16, 5'd0, 5'd31, 5'd2, 5'd1, 5'd17, 5'd8, 5'd3, 5'd16, 5'd12, 5'd4};

    // model after reset: both stores in the cleared pattern, full vertex count
    wipe_edges();
    vcount_shadow = '0;
    void'(graph_answer('{op: OP_COMPUTE, node_a: '0, node_b: '0, weight: '0}));
    vcount_shadow = VCOUNT_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fresh stores, diagonal weight, overwrite, stale distances
    queue_req(OP_READ,    4'd0,  4'd0,  16'h0000);  // diagonal reads zero
    queue_req(OP_READ,    4'd0,  4'd15, 16'hffff);  // nothing reachable yet
    queue_req(OP_ADD,     4'd0,  4'd1,  16'h0000);  // zero weight edge
    queue_req(OP_ADD,     4'd1,  4'd2,  W_MAX);
    queue_req(OP_ADD,     4'd2,  4'd15, 16'h1234);
    queue_req(OP_ADD,     4'd3,  4'd3,  16'd7);     // self loop lands on the diagonal
    queue_req(OP_ADD,     4'd4,  4'd5,  16'd100);
    queue_req(OP_ADD,     4'd5,  4'd4,  16'd50);    // reverse direction overwrites
    queue_req(OP_READ,    4'd0,  4'd2,  16'h0000);  // not solved yet
    queue_req(OP_COMPUTE, 4'd15, 4'd15, W_MAX);     // node and weight ignored
    queue_req(OP_READ,    4'd0,  4'd15, 16'h0000);
    queue_req(OP_READ,    4'd15, 4'd0,  16'h0000);
    queue_req(OP_READ,    4'd3,  4'd3,  16'h0000);
    queue_req(OP_READ,    4'd5,  4'd4,  16'h0000);
    queue_req(OP_READ,    4'd6,  4'd7,  16'h0000);  // unreachable pair
    queue_req(OP_CLEAR,   4'd15, 4'd15, W_MAX);
    queue_req(OP_READ,    4'd0,  4'd15, 16'h0000);  // distances survive a clear
    queue_req(OP_COMPUTE, 4'd0,  4'd0,  16'h0000);
    queue_req(OP_READ,    4'd0,  4'd15, 16'h0000);
    queue_req(OP_READ,    4'd3,  4'd3,  16'h0000);
    // small graph: indices past the vertex count are refused
    set_vertex_count(5'd2);
    queue_req(OP_ADD,     4'd1,  4'd0,  16'd9);
    queue_req(OP_ADD,     4'd2,  4'd0,  16'd1);
    queue_req(OP_READ,    4'd15, 4'd1,  16'h0000);
    queue_req(OP_COMPUTE, 4'd0,  4'd0,  16'h0000);
    queue_req(OP_READ,    4'd0,  4'd1,  16'h0000);
    directed_end = queued_total;

    // a full chain of heaviest edges gives the longest distance possible
    set_vertex_count(5'd31);
    queue_req(OP_CLEAR, 4'd0, 4'd0, 16'h0000);
    for (int i = 0; i < NV - 1; i++)
      queue_req(OP_ADD, NODE_BITS'(i), NODE_BITS'(i + 1), W_MAX);
    queue_req(OP_COMPUTE, 4'd0, 4'd0, 16'h0000);
    queue_req(OP_READ, 4'd0, 4'd15, 16'h0000);
    queue_req(OP_READ, 4'd15, 4'd0, 16'h0000);
    queue_req(OP_READ, 4'd0, 4'd8, 16'h0000);

    plan_idx = 0;
    while (queued_total - directed_end < RANDOM_ITEMS) begin
      graph_session(vc_plan[plan_idx % 12]);
      plan_idx++;
    end

    wait_idle();
    repeat (40) @(posedge clk);

    $display("ran %0d requests (%0d clear, %0d add, %0d solve, %0d read), %0d results checked",
             queued_total, op_tally[OP_CLEAR], op_tally[OP_ADD], op_tally[OP_COMPUTE],
             op_tally[OP_READ], answers_seen);
    $display("%0d reads found a path, %0d out-of-range requests, %0d vertex count writes",
             reach_count, range_count, vcount_writes);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[all_pairs_shortest_path_core.f]
+incdir+rtl
rtl/aps_pkg.sv
rtl/aps_relax.sv
rtl/aps_engine.sv
rtl/all_pairs_shortest_path_core.sv
tb/all_pairs_shortest_path_core_test.sv
